@@ rtl/core/roman_numeral_decoder_defines.svh @@
// Assertion macros for the Roman numeral decoder.
// Self-contained; included by the RTL files that carry assertions.
`ifndef ROMAN_NUMERAL_DECODER_DEFINES_SVH
`define ROMAN_NUMERAL_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property at every clock edge outside reset
`define RND_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("roman numeral decoder assertion failed");
// Check a property at every clock edge, reset included
`define RND_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("roman numeral decoder assertion failed");
`else
`define RND_ASSERT(label, clk, rst_n, prop)
`define RND_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

@@ rtl/core/rnd_pkg.sv @@
// Package for the Roman numeral decoder: digit codes, limits and lookups.
// No dependencies.
`timescale 1ns / 1ps

package rnd_pkg;

    typedef logic [2:0]  digit_t;
    typedef logic [9:0]  digit_val_t;
    typedef logic [12:0] total_t;

    localparam digit_t DIG_I    = 3'd0;
    localparam digit_t DIG_V    = 3'd1;
    localparam digit_t DIG_X    = 3'd2;
    localparam digit_t DIG_L    = 3'd3;
    localparam digit_t DIG_C    = 3'd4;
    localparam digit_t DIG_D    = 3'd5;
    localparam digit_t DIG_M    = 3'd6;
    localparam digit_t DIG_NONE = 3'd7;

    localparam logic [1:0] MAX_REPEAT = 2'd3;
    localparam logic [2:0] MAX_STEP   = 3'd2;
    localparam total_t     MAX_VALUE  = 13'd3999;

    // Map an ASCII character to a digit code
    function automatic digit_t decode_symbol(input logic [7:0] c);
        digit_t d;
        unique case (c)
            8'h49:   d = DIG_I;
            8'h56:   d = DIG_V;
            8'h58:   d = DIG_X;
            8'h4C:   d = DIG_L;
            8'h43:   d = DIG_C;
            8'h44:   d = DIG_D;
            8'h4D:   d = DIG_M;
            default: d = DIG_NONE;
        endcase
        return d;
    endfunction

    // Value of a digit code; the unused code wraps onto I
    function automatic digit_val_t digit_value(input digit_t d);
        digit_val_t v;
        unique case (d)
            DIG_V:   v = 10'd5;
            DIG_X:   v = 10'd10;
            DIG_L:   v = 10'd50;
            DIG_C:   v = 10'd100;
            DIG_D:   v = 10'd500;
            DIG_M:   v = 10'd1000;
            default: v = 10'd1;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/core/roman_numeral_decoder.sv @@
// The result appears in the cycle after the transfer of the character marked last.
// Throughput: one character per cycle unless stalled; each step is a decode, a few compares and two adds.
// A last character stalls only while the result register holds a result not yet taken.
// Reset (rst_n, async, active low) clears the digit history, total, error flag and
// the result valid; the block takes characters right after reset.
// Depends on rnd_pkg and roman_numeral_decoder_defines.svh.
`timescale 1ns / 1ps
`include "roman_numeral_decoder_defines.svh"

module roman_numeral_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  symbol,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        valid_res,
    output logic [11:0] number
);
    import rnd_pkg::*;

    // Numeral state
    digit_t     prev_digit_reg, prev_digit_next;
    digit_t     before_prev_digit_reg, before_prev_digit_next;
    logic       has_prev_reg, has_prev_next;
    logic       has_before_prev_reg, has_before_prev_next;
    logic [1:0] repeat_count_reg, repeat_count_next;
    digit_t     guard_digit_reg, guard_digit_next;
    logic       guard_active_reg, guard_active_next;
    total_t     running_total_reg, running_total_next;
    logic       failed_reg, failed_next;

    // Result register
    logic        out_valid_reg;
    logic        valid_res_reg, valid_res_next;
    logic [11:0] number_reg, number_next;

    logic   in_xfer;
    digit_t code;
    total_t prev_val;
    total_t final_total;

    // Hold a last character only while the pending result is not taken
    assign in_stall = out_valid_reg && out_stall && last;
    assign in_xfer  = in_valid && !in_stall;
    assign code     = decode_symbol(symbol);
    assign prev_val = {3'b000, digit_value(prev_digit_reg)};

    // Settle the previous digit against the incoming one and apply the rules
    always_comb
    begin
        prev_digit_next        = prev_digit_reg;
        before_prev_digit_next = before_prev_digit_reg;
        has_prev_next          = has_prev_reg;
        has_before_prev_next   = has_before_prev_reg;
        repeat_count_next      = repeat_count_reg;
        guard_digit_next       = guard_digit_reg;
        guard_active_next      = guard_active_reg;
        running_total_next     = running_total_reg;
        failed_next            = failed_reg;

        if (!failed_reg)
        begin
            if (code == DIG_NONE)
            begin
                failed_next = 1'b1;
            end
            else
            begin
                // Digit after a subtractive pair must stay below the subtracted one
                if (guard_active_reg && code >= guard_digit_reg)
                    failed_next = 1'b1;
                guard_active_next = 1'b0;

                // Count runs of equal digits
                if (has_prev_reg && code == prev_digit_reg)
                begin
                    if (code == DIG_V || code == DIG_L || code == DIG_D)
                        failed_next = 1'b1;
                    if (repeat_count_reg >= MAX_REPEAT)
                        failed_next = 1'b1;
                    else
                        repeat_count_next = repeat_count_reg + 2'd1;
                end
                else
                begin
                    repeat_count_next = 2'd1;
                end

                // Subtract a smaller previous digit, otherwise add it
                if (has_prev_reg)
                begin
                    if (prev_digit_reg < code)
                    begin
                        if (prev_digit_reg[0] || prev_digit_reg > DIG_C
                            || (code - prev_digit_reg) > MAX_STEP)
                            failed_next = 1'b1;
                        if (has_before_prev_reg && before_prev_digit_reg < prev_digit_reg)
                            failed_next = 1'b1;
                        guard_digit_next   = prev_digit_reg;
                        guard_active_next  = 1'b1;
                        running_total_next = running_total_reg - prev_val;
                    end
                    else
                    begin
                        running_total_next = running_total_reg + prev_val;
                    end
                end

                before_prev_digit_next = prev_digit_reg;
                has_before_prev_next   = has_prev_reg;
                prev_digit_next        = code;
                has_prev_next          = 1'b1;
            end
        end
    end

    // Close the numeral: add the final digit and range check
    always_comb
    begin
        final_total    = running_total_next + {3'b000, digit_value(prev_digit_next)};
        valid_res_next = !failed_next && (final_total <= MAX_VALUE);
        number_next    = valid_res_next ? final_total[11:0] : 12'd0;
    end

    // Advance the numeral state; clear it after the last character
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_digit_reg        <= DIG_I;
            before_prev_digit_reg <= DIG_I;
            has_prev_reg          <= 1'b0;
            has_before_prev_reg   <= 1'b0;
            repeat_count_reg      <= 2'd1;
            guard_digit_reg       <= DIG_I;
            guard_active_reg      <= 1'b0;
            running_total_reg     <= '0;
            failed_reg            <= 1'b0;
        end
        else if (in_xfer)
        begin
            if (last)
            begin
                prev_digit_reg        <= DIG_I;
                before_prev_digit_reg <= DIG_I;
                has_prev_reg          <= 1'b0;
                has_before_prev_reg   <= 1'b0;
                repeat_count_reg      <= 2'd1;
                guard_digit_reg       <= DIG_I;
                guard_active_reg      <= 1'b0;
                running_total_reg     <= '0;
                failed_reg            <= 1'b0;
            end
            else
            begin
                prev_digit_reg        <= prev_digit_next;
                before_prev_digit_reg <= before_prev_digit_next;
                has_prev_reg          <= has_prev_next;
                has_before_prev_reg   <= has_before_prev_next;
                repeat_count_reg      <= repeat_count_next;
                guard_digit_reg       <= guard_digit_next;
                guard_active_reg      <= guard_active_next;
                running_total_reg     <= running_total_next;
                failed_reg            <= failed_next;
            end
        end
    end

    // Result valid: set on a last transfer, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_xfer && last)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (in_xfer && last)
        begin
            valid_res_reg <= valid_res_next;
            number_reg    <= number_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign valid_res = valid_res_reg;
    assign number    = number_reg;

    // Checks
    `RND_ASSERT(a_repeat_nonzero, clk, rst_n, repeat_count_reg != 2'd0)
    `RND_ASSERT(a_guard_has_prev, clk, rst_n, guard_active_reg |-> has_before_prev_reg && has_prev_reg)
    `RND_ASSERT(a_history_order, clk, rst_n, has_before_prev_reg |-> has_prev_reg)
    `RND_ASSERT(a_last_clears, clk, rst_n, (in_xfer && last) |=> (!has_prev_reg && !failed_reg && out_valid_reg))
    `RND_ASSERT(a_invalid_zero, clk, rst_n, (out_valid_reg && !valid_res_reg) |-> number_reg == 12'd0)

endmodule
